// File: sv/vpd_pkg.sv
// ----------------------------------------------------------------------------
// vpd_pkg
// Shared types and constants for the variable-byte posting list decoder.
// ----------------------------------------------------------------------------
package vpd_pkg;

    localparam int FIELD_W        = 31;
    localparam int VALUE_BITS_DEF = 31;
    localparam int GROUP_BITS     = 7;
    localparam int BYTE_W         = 8;
    localparam int STOP_BIT       = 7;

    typedef enum logic [1:0] {
        PH_TERM  = 2'd0,
        PH_COUNT = 2'd1,
        PH_GAPS  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [FIELD_W-1:0] term_id;
        logic [FIELD_W-1:0] doc_id;
        logic               last_in_list;
        logic               empty_list;
        logic               overflow;
    } result_t;

endpackage

// File: sv/vpd_parse.sv
// ----------------------------------------------------------------------------
// vpd_parse
// Parse state and combinational decode step: assembles 7-bit groups, tracks
// the list phase, accumulates gaps into document ids.
// ----------------------------------------------------------------------------
module vpd_parse
    import vpd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [BYTE_W-1:0] code_byte,
    input  logic              restart,
    output logic              res_valid,
    output result_t           res
);

    localparam int MAX_GROUPS = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int ACC_W      = MAX_GROUPS * GROUP_BITS;
    localparam int GI_W       = $clog2(MAX_GROUPS + 1);
    localparam int EXT_W      = FIELD_W + VALUE_BITS;

    phase_t                phase_reg, phase_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [GI_W-1:0]       gi_reg, gi_next;
    logic [VALUE_BITS-1:0] term_reg, term_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] doc_reg, doc_next;
    logic                  ovf_reg, ovf_next;

    // state as seen after an optional restart
    phase_t                b_phase;
    logic [ACC_W-1:0]      b_acc;
    logic [GI_W-1:0]       b_gi;
    logic [VALUE_BITS-1:0] b_term, b_rem, b_doc;
    logic                  b_ovf;

    logic [ACC_W-1:0]      acc_cur;
    logic [ACC_W:0]        acc_pad;
    logic                  room;
    logic                  big;
    logic                  ovf_cur;
    logic [VALUE_BITS-1:0] value;
    logic [VALUE_BITS:0]   doc_sum;
    logic [VALUE_BITS-1:0] rem_dec;
    logic                  stop;
    logic [EXT_W-1:0]      term_ext, doc_ext;

    always_comb begin
        b_phase = restart ? PH_TERM : phase_reg;
        b_acc   = restart ? '0 : acc_reg;
        b_gi    = restart ? '0 : gi_reg;
        b_term  = restart ? '0 : term_reg;
        b_rem   = restart ? '0 : rem_reg;
        b_doc   = restart ? '0 : doc_reg;
        b_ovf   = restart ? 1'b0 : ovf_reg;
    end

    always_comb begin
        room    = (b_gi < GI_W'(MAX_GROUPS));
        acc_cur = b_acc;
        for (int g = 0; g < MAX_GROUPS; g++) begin
            if (b_gi == GI_W'(g)) begin
                acc_cur[g*GROUP_BITS +: GROUP_BITS] = acc_cur[g*GROUP_BITS +: GROUP_BITS]
                                                     | code_byte[GROUP_BITS-1:0];
            end
        end
        acc_pad = {1'b0, acc_cur};
        big     = ((acc_pad >> VALUE_BITS) != '0);
        value   = acc_cur[VALUE_BITS-1:0];
        stop    = code_byte[STOP_BIT];
        doc_sum = {1'b0, b_doc} + {1'b0, value};
        rem_dec = b_rem - VALUE_BITS'(1);
        ovf_cur = b_ovf | ~room | (stop & big);
    end

    // next state
    always_comb begin
        phase_next = b_phase;
        acc_next   = acc_cur;
        gi_next    = room ? b_gi + GI_W'(1) : b_gi;
        term_next  = b_term;
        rem_next   = b_rem;
        doc_next   = b_doc;
        ovf_next   = ovf_cur;
        if (stop) begin
            acc_next = '0;
            gi_next  = '0;
            case (b_phase)
                PH_COUNT: begin
                    rem_next = value;
                    doc_next = '0;
                    if (value == '0) begin
                        phase_next = PH_TERM;
                        ovf_next   = 1'b0;
                    end else begin
                        phase_next = PH_GAPS;
                    end
                end
                PH_GAPS: begin
                    doc_next = doc_sum[VALUE_BITS-1:0];
                    rem_next = rem_dec;
                    ovf_next = ovf_cur | doc_sum[VALUE_BITS];
                    if (rem_dec == '0) begin
                        phase_next = PH_TERM;
                        ovf_next   = 1'b0;
                    end
                end
                default: begin
                    term_next  = value;
                    phase_next = PH_COUNT;
                end
            endcase
        end
    end

    // result
    always_comb begin
        term_ext         = {{FIELD_W{1'b0}}, b_term};
        doc_ext          = {{FIELD_W{1'b0}}, doc_sum[VALUE_BITS-1:0]};
        res_valid        = 1'b0;
        res.term_id      = term_ext[FIELD_W-1:0];
        res.doc_id       = doc_ext[FIELD_W-1:0];
        res.last_in_list = (rem_dec == '0);
        res.empty_list   = 1'b0;
        res.overflow     = ovf_cur | doc_sum[VALUE_BITS];
        case (b_phase)
            PH_COUNT: begin
                res_valid        = stop && (value == '0);
                res.doc_id       = '0;
                res.last_in_list = 1'b1;
                res.empty_list   = 1'b1;
                res.overflow     = ovf_cur;
            end
            PH_GAPS: begin
                res_valid = stop;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TERM;
            acc_reg   <= '0;
            gi_reg    <= '0;
            term_reg  <= '0;
            rem_reg   <= '0;
            doc_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            gi_reg    <= gi_next;
            term_reg  <= term_next;
            rem_reg   <= rem_next;
            doc_reg   <= doc_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// File: sv/vbyte_posting_decoder_core.sv
// ----------------------------------------------------------------------------
// vbyte_posting_decoder_core
// Variable-byte posting list decoder: byte stream in, document ids out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one code byte per item, with s_restart to drop any partial
//   list and start a fresh one at that byte. m_* carries one result item per
//   decoded document id (term id, doc id, last mark, overflow), or a single
//   empty-list marker for a list of count zero. Bytes that do not close a
//   gap or a zero count give no result.
//   Throughput: one byte per cycle while m_ready does not stall. A closing
//   byte is first loaded into the input register; its decode step is then
//   loaded into the result register, from which the result is offered on m_*.
//   A stalled m_ready holds the result register; the input register still
//   takes one more byte, then s_ready drops until the result is taken.
//   Reset (aresetn low, synchronous) clears all parse and list state and
//   empties both registers.
// ----------------------------------------------------------------------------
module vbyte_posting_decoder_core
    import vpd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BYTE_W-1:0]  s_code_byte,
    input  logic               s_restart,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FIELD_W-1:0] m_term_id,
    output logic [FIELD_W-1:0] m_doc_id,
    output logic               m_last_in_list,
    output logic               m_empty_list,
    output logic               m_overflow
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_restart_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic              adv;
    logic              step_en;
    logic              res_valid;
    result_t           res;

    assign adv     = !out_valid_reg || m_ready;
    assign step_en = in_valid_reg && adv;
    assign s_ready = !in_valid_reg || adv;

    vpd_parse #(
        .VALUE_BITS(VALUE_BITS)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .code_byte (in_byte_reg),
        .restart   (in_restart_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg    <= s_code_byte;
            in_restart_reg <= s_restart;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= step_en && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_term_id      = out_reg.term_id;
    assign m_doc_id       = out_reg.doc_id;
    assign m_last_in_list = out_reg.last_in_list;
    assign m_empty_list   = out_reg.empty_list;
    assign m_overflow     = out_reg.overflow;

    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without a decoded item");

    a_marker_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_empty_list) |-> (m_last_in_list && (m_doc_id == '0)))
        else $error("empty-list marker malformed");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input blocked without a held result");

endmodule

// File: test/tb_vbyte_posting_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_vbyte_posting_decoder_core
// Self-checking bench for the variable-byte posting list decoder. A short
// table of directed bytes covers the field extremes, a zero count, too many
// groups, a value wider than 31 bits and a restart in the middle of a number.
// Random posting lists follow, along with noise bytes and lists cut short.
// The table's expected items and a local decoder model predict every item,
// and each item from the block is compared field by field in order. Both
// sides idle at random, and the receiver stalls once for a long stretch to
// fill the block.
module tb_vbyte_posting_decoder_core;
    import vpd_pkg::*;

    localparam int MAX_GROUPS = (VALUE_BITS_DEF + GROUP_BITS - 1) / GROUP_BITS;
    localparam int ACC_W      = MAX_GROUPS * GROUP_BITS;
    localparam int DIR_N      = 26;
    localparam int RAND_ITEMS = 500;
    localparam int STALL_LONG = 300;
    localparam int TAIL       = 8;
    localparam int WATCHDOG   = 4000;

    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic              rst;
        logic              known;
        result_t           want;
    } row_t;

    localparam row_t DIR_ROWS [DIR_N] = '{
        '{8'h85, 1'b1, 1'b0, '0},
        '{8'h80, 1'b0, 1'b1, '{31'd5, 31'd0, 1'b1, 1'b1, 1'b0}},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h81, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, '0},
        '{8'h87, 1'b0, 1'b1, '{31'd127, 31'h7FFFFFFF, 1'b1, 1'b0, 1'b0}},
        '{8'h7F, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, '0},
        '{8'h8F, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b1, '{31'h7FFFFFFF, 31'd0, 1'b1, 1'b1, 1'b1}},
        '{8'h83, 1'b1, 1'b0, '0},
        '{8'h02, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h81, 1'b0, 1'b1, '{31'd3, 31'd1, 1'b0, 1'b0, 1'b1}},
        '{8'h7F, 1'b0, 1'b0, '0},
        '{8'h85, 1'b1, 1'b0, '0},
        '{8'h80, 1'b0, 1'b1, '{31'd5, 31'd0, 1'b1, 1'b1, 1'b0}}
    };

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [BYTE_W-1:0]  s_code_byte;
    logic               s_restart;
    logic               m_valid;
    logic               m_ready;
    logic [FIELD_W-1:0] m_term_id;
    logic [FIELD_W-1:0] m_doc_id;
    logic               m_last_in_list;
    logic               m_empty_list;
    logic               m_overflow;

    vbyte_posting_decoder_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code_byte    (s_code_byte),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_term_id      (m_term_id),
        .m_doc_id       (m_doc_id),
        .m_last_in_list (m_last_in_list),
        .m_empty_list   (m_empty_list),
        .m_overflow     (m_overflow)
    );

    row_t        code_stream [$];
    result_t     pending_docs [$];
    bit          failed;
    int unsigned bytes_taken;
    int unsigned idle_cycles;

    // decoder model state
    phase_t             ph_r     = PH_TERM;
    logic [ACC_W-1:0]   acc_r    = '0;
    logic [2:0]         grp_r    = '0;
    logic [FIELD_W-1:0] term_r   = '0;
    logic [FIELD_W-1:0] left_r   = '0;
    logic [FIELD_W-1:0] doc_r    = '0;
    logic               trunc_r  = 1'b0;
    result_t            next_doc;
    bit                 has_doc;

    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic rst,
                                       output result_t r);
        logic [FIELD_W:0]   sum;
        logic [FIELD_W-1:0] val;
        bit                 got;
        got = 1'b0;
        r = '0;
        if (rst) begin
            ph_r = PH_TERM;
            acc_r = '0;
            grp_r = '0;
            term_r = '0;
            left_r = '0;
            doc_r = '0;
            trunc_r = 1'b0;
        end
        if (grp_r < MAX_GROUPS) begin
            acc_r = acc_r | (ACC_W'(b[GROUP_BITS-1:0]) << (GROUP_BITS * grp_r));
            grp_r = grp_r + 1'b1;
        end else begin
            trunc_r = 1'b1;
        end
        if (!b[STOP_BIT])
            return 1'b0;
        if ((acc_r >> FIELD_W) != 0)
            trunc_r = 1'b1;
        val = acc_r[FIELD_W-1:0];
        acc_r = '0;
        grp_r = '0;
        case (ph_r)
            PH_COUNT: begin
                left_r = val;
                doc_r = '0;
                if (val == 0) begin
                    r = '{term_r, '0, 1'b1, 1'b1, trunc_r};
                    got = 1'b1;
                    ph_r = PH_TERM;
                    trunc_r = 1'b0;
                end else begin
                    ph_r = PH_GAPS;
                end
            end
            PH_GAPS: begin
                sum = {1'b0, doc_r} + {1'b0, val};
                if (sum[FIELD_W])
                    trunc_r = 1'b1;
                doc_r = sum[FIELD_W-1:0];
                left_r = left_r - 1'b1;
                r = '{term_r, doc_r, left_r == 0, 1'b0, trunc_r};
                got = 1'b1;
                if (left_r == 0) begin
                    ph_r = PH_TERM;
                    trunc_r = 1'b0;
                end
            end
            default: begin
                term_r = val;
                ph_r = PH_COUNT;
            end
        endcase
        return got;
    endfunction

    function automatic logic [ACC_W-1:0] pick_value();
        int k;
        k = $urandom_range(0, 19);
        if (k < 10)
            return ACC_W'($urandom_range(0, 127));
        if (k < 15)
            return ACC_W'($urandom_range(0, 20000));
        if (k < 18)
            return {4'd0, 31'($urandom)};
        return {4'($urandom_range(1, 15)), 31'($urandom)};
    endfunction

    // minimal, zero-padded, or overlong with junk groups past the kept ones
    task automatic put_number(input logic [ACC_W-1:0] v, input logic rst);
        int   n;
        int   total;
        int   mode;
        row_t row;
        n = 1;
        while (n < MAX_GROUPS && (v >> (GROUP_BITS * n)) != 0)
            n++;
        mode = $urandom_range(0, 9);
        total = n;
        if (mode == 0)
            total = MAX_GROUPS + $urandom_range(1, 3);
        else if (mode < 3)
            total = $urandom_range(n, MAX_GROUPS);
        for (int k = 0; k < total; k++) begin
            row = '0;
            row.rst = (k == 0) ? rst : 1'b0;
            if (k < n)
                row.code[GROUP_BITS-1:0] = v[k*GROUP_BITS +: GROUP_BITS];
            else if (k >= MAX_GROUPS)
                row.code[GROUP_BITS-1:0] = GROUP_BITS'($urandom);
            row.code[STOP_BIT] = (k == total - 1);
            code_stream.insert(code_stream.size(), row);
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            has_doc = decode_byte(s_code_byte, s_restart, next_doc);
            if (code_stream[bytes_taken].known)
                pending_docs.insert(pending_docs.size(), code_stream[bytes_taken].want);
            else if (has_doc)
                pending_docs.insert(pending_docs.size(), next_doc);
            bytes_taken++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_docs.size() == 0) begin
                $error("unexpected item: term_id %0d doc_id %0d", m_term_id, m_doc_id);
                failed = 1'b1;
            end else begin
                automatic result_t w = pending_docs.pop_front();
                if (m_term_id !== w.term_id) begin
                    $error("term_id: expected %0d, got %0d", w.term_id, m_term_id);
                    failed = 1'b1;
                end
                if (m_doc_id !== w.doc_id) begin
                    $error("doc_id: expected %0d, got %0d", w.doc_id, m_doc_id);
                    failed = 1'b1;
                end
                if (m_last_in_list !== w.last_in_list) begin
                    $error("last_in_list: expected %0b, got %0b", w.last_in_list,
                           m_last_in_list);
                    failed = 1'b1;
                end
                if (m_empty_list !== w.empty_list) begin
                    $error("empty_list: expected %0b, got %0b", w.empty_list, m_empty_list);
                    failed = 1'b1;
                end
                if (m_overflow !== w.overflow) begin
                    $error("overflow: expected %0b, got %0b", w.overflow, m_overflow);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side
    initial begin
        int unsigned n_recv;
        int unsigned gap;
        n_recv = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (n_recv == 50)
                gap = STALL_LONG;
            else if ((n_recv / 32) % 3 == 2)
                gap = 0;
            else
                gap = $urandom_range(0, 16);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid)
                @(posedge aclk);
            n_recv++;
        end
    end

    // byte side
    initial begin
        int   kind;
        int   cnt;
        int   mark;
        int   gap;
        logic force_rst;
        row_t row;
        failed = 1'b0;
        bytes_taken = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_code_byte <= '0;
        s_restart <= 1'b0;

        for (int i = 0; i < DIR_N; i++)
            code_stream.insert(code_stream.size(), DIR_ROWS[i]);
        force_rst = 1'b0;
        while (code_stream.size() < DIR_N + RAND_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 12) begin
                repeat ($urandom_range(1, 6)) begin
                    row = '0;
                    row.code = BYTE_W'($urandom);
                    row.rst = ($urandom_range(0, 3) == 0);
                    code_stream.insert(code_stream.size(), row);
                end
                force_rst = 1'b1;
            end else begin
                mark = code_stream.size();
                put_number(pick_value(), force_rst | ($urandom_range(0, 3) == 0));
                cnt = $urandom_range(0, 9);
                if (cnt >= 8)
                    cnt = $urandom_range(7, 20);
                else if (cnt > 0)
                    cnt = $urandom_range(1, 6);
                put_number(ACC_W'(cnt), 1'b0);
                repeat (cnt) put_number(pick_value(), 1'b0);
                force_rst = 1'b0;
                // list cut short, next one restarts
                if (kind < 22) begin
                    repeat ($urandom_range(1, code_stream.size() - mark))
                        void'(code_stream.pop_back());
                    force_rst = 1'b1;
                end
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < code_stream.size(); i++) begin
            gap = ((i / 48) % 3 == 2) ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_code_byte <= code_stream[i].code;
            s_restart <= code_stream[i].rst;
            @(posedge aclk);
            while (!s_ready)
                @(posedge aclk);
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending_docs.size() != 0)
            @(posedge aclk);
        repeat (TAIL) @(posedge aclk);
        if (!failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: vbyte_posting_decoder_core.f
sv/vpd_pkg.sv
sv/vpd_parse.sv
sv/vbyte_posting_decoder_core.sv
test/tb_vbyte_posting_decoder_core.sv
